// File: hdl/lesq_pkg.sv
`default_nettype none
package lesq_pkg;
  localparam int MAX_SIDE = 64;
  localparam int IDX_W = $clog2(MAX_SIDE);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int SIDE_W = 7;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] CELL_EMPTY = 2'd0;
  localparam logic [1:0] CELL_BLOCKED = 2'd1;
  localparam logic [1:0] CELL_MARKED = 2'd2;

  localparam logic [2:0] REG_GRID_SIDE = 3'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIZE,
    ST_GAP1,
    ST_HORZ,
    ST_GAP2,
    ST_VERT,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

// File: hdl/largest_empty_square_search.sv
`default_nettype none
// Grid of up to 64x64 cells held in two simple dual-port RAMs (cell codes and
// per-corner square sides). A write word updates the cell RAM as it is taken. A
// read word's result passes through the registered RAM read and then the output
// register, and input is held off until it is valid. A search word walks the grid
// in use (n = min(grid_side, 64) cells a side) three times, one cell per cycle
// through the RAM read/modify/write loop: a sizing pass from the bottom-right
// corner, a row pass and a column pass that mark the union of all best squares.
// Input is held off until the search result is valid. The marking passes are
// skipped when no empty cell exists.
module largest_empty_square_search (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] operation, [7:2] row, [13:8] col, [14] blocked, [15] zero
  input  wire logic [15:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [1:0] cell_code, [8:2] best_side, [15:9] zero
  output logic [15:0]      out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int IW = lesq_pkg::IDX_W;
  localparam int AW = lesq_pkg::ADDR_W;
  localparam int SW = lesq_pkg::SIDE_W;
  localparam int DEPTH = lesq_pkg::MAX_SIDE * lesq_pkg::MAX_SIDE;

  logic [1:0]    cell_mem [DEPTH];
  logic [SW-1:0] size_mem [DEPTH];

  lesq_pkg::state_t state_r, state_nxt;
  logic [SW-1:0] grid_side_r;
  logic [SW-1:0] best_side_r, best_side_nxt;
  logic [IW-1:0] r_r, r_nxt, c_r, c_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_code_r, out_code_nxt;
  logic          rd_pend_r;

  logic          st_v_r;
  lesq_pkg::state_t st_ph_r;
  logic [IW-1:0] st_row_r, st_col_r;
  logic          st_first_r, st_edge_r;
  logic [SW-1:0] b_r, d_r, cnt_r;
  logic [SW-1:0] b_nxt, d_nxt, cnt_nxt;

  logic [1:0]    cell_q;
  logic [SW-1:0] size_q;

  logic [1:0]  in_op;
  logic [IW-1:0] in_row, in_col;
  logic        in_blk, in_fire, cfg_wr;
  logic [SW-1:0] n;
  logic [IW-1:0] n1;
  logic        issue, issue_last, issue_first, issue_edge;

  logic          cw_en, sw_en;
  logic [AW-1:0] cw_addr, sw_addr, cr_addr, sr_addr;
  logic [1:0]    cw_data;
  logic [SW-1:0] sw_data;

  logic [SW-1:0] a_eff, b_eff, d_eff, m, s, cnt_eff, cnt_new;
  logic          f;

  assign in_op  = in_tdata[1:0];
  assign in_row = in_tdata[7:2];
  assign in_col = in_tdata[13:8];
  assign in_blk = in_tdata[14];
  assign in_tready = (state_r == lesq_pkg::ST_IDLE) && !rd_pend_r &&
                     (!out_valid_r || out_tready);
  assign in_fire = in_tvalid && in_tready;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == lesq_pkg::REG_GRID_SIDE) ?
                      {{(32-SW){1'b0}}, grid_side_r} : 32'd0;

  assign out_tvalid = out_valid_r;
  assign out_tdata = {7'd0, best_side_r, out_code_r};

  assign n = (grid_side_r > SW'(lesq_pkg::MAX_SIDE)) ? SW'(lesq_pkg::MAX_SIDE) : grid_side_r;
  assign n1 = IW'(n - SW'(1));

  // scanner: next state and counters
  always_comb begin
    state_nxt = state_r;
    r_nxt = r_r;
    c_nxt = c_r;
    issue = 1'b0;
    issue_last = 1'b0;
    issue_first = 1'b0;
    issue_edge = 1'b0;
    case (state_r)
      lesq_pkg::ST_IDLE: begin
        if (in_fire && in_op == lesq_pkg::OP_SEARCH) begin
          r_nxt = n1;
          c_nxt = n1;
          state_nxt = (n == '0) ? lesq_pkg::ST_DONE : lesq_pkg::ST_SIZE;
        end
      end
      lesq_pkg::ST_SIZE: begin
        issue = 1'b1;
        issue_first = (c_r == n1);
        issue_edge = (r_r == n1);
        issue_last = (r_r == '0) && (c_r == '0);
        if (c_r == '0) begin
          c_nxt = n1;
          r_nxt = r_r - IW'(1);
        end else begin
          c_nxt = c_r - IW'(1);
        end
        if (issue_last) begin
          state_nxt = lesq_pkg::ST_GAP1;
        end
      end
      lesq_pkg::ST_GAP1: begin
        r_nxt = '0;
        c_nxt = '0;
        // the last sized cell is still in the processing stage here
        state_nxt = (best_side_nxt == '0) ? lesq_pkg::ST_DONE : lesq_pkg::ST_HORZ;
      end
      lesq_pkg::ST_HORZ: begin
        issue = 1'b1;
        issue_first = (c_r == '0);
        issue_last = (r_r == n1) && (c_r == n1);
        if (c_r == n1) begin
          c_nxt = '0;
          r_nxt = r_r + IW'(1);
        end else begin
          c_nxt = c_r + IW'(1);
        end
        if (issue_last) begin
          state_nxt = lesq_pkg::ST_GAP2;
        end
      end
      lesq_pkg::ST_GAP2: begin
        r_nxt = '0;
        c_nxt = '0;
        state_nxt = lesq_pkg::ST_VERT;
      end
      lesq_pkg::ST_VERT: begin
        issue = 1'b1;
        issue_first = (r_r == '0);
        issue_last = (r_r == n1) && (c_r == n1);
        if (r_r == n1) begin
          r_nxt = '0;
          c_nxt = c_r + IW'(1);
        end else begin
          r_nxt = r_r + IW'(1);
        end
        if (issue_last) begin
          state_nxt = lesq_pkg::ST_DONE;
        end
      end
      lesq_pkg::ST_DONE: begin
        state_nxt = lesq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lesq_pkg::ST_IDLE;
      end
    endcase
  end

  // processing stage on registered RAM data
  always_comb begin
    a_eff = (st_edge_r) ? '0 : size_q;
    b_eff = (st_first_r) ? '0 : b_r;
    d_eff = (st_first_r) ? '0 : d_r;
    m = (a_eff < b_eff) ? a_eff : b_eff;
    if (d_eff < m) begin
      m = d_eff;
    end
    s = (cell_q == lesq_pkg::CELL_BLOCKED) ? '0 : m + SW'(1);
    f = (st_ph_r == lesq_pkg::ST_HORZ) ? (size_q >= best_side_r) : size_q[0];
    cnt_eff = (st_first_r) ? '0 : cnt_r;
    if (f) begin
      cnt_new = best_side_r;
    end else if (cnt_eff != '0) begin
      cnt_new = cnt_eff - SW'(1);
    end else begin
      cnt_new = '0;
    end
  end

  always_comb begin
    best_side_nxt = best_side_r;
    b_nxt = b_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    sw_en = 1'b0;
    sw_data = '0;
    cw_en = 1'b0;
    cw_addr = {in_row, in_col};
    cw_data = in_blk ? lesq_pkg::CELL_BLOCKED : lesq_pkg::CELL_EMPTY;
    sw_addr = {st_row_r, st_col_r};
    if (in_fire && in_op == lesq_pkg::OP_WRITE) begin
      cw_en = 1'b1;
    end
    if (in_fire && in_op == lesq_pkg::OP_SEARCH) begin
      best_side_nxt = '0;
    end
    if (st_v_r) begin
      case (st_ph_r)
        lesq_pkg::ST_SIZE: begin
          sw_en = 1'b1;
          sw_data = s;
          b_nxt = s;
          d_nxt = a_eff;
          if (s > best_side_r) begin
            best_side_nxt = s;
          end
        end
        lesq_pkg::ST_HORZ: begin
          sw_en = 1'b1;
          sw_data = {{(SW-1){1'b0}}, (cnt_new != '0)};
          cnt_nxt = cnt_new;
        end
        lesq_pkg::ST_VERT: begin
          cnt_nxt = cnt_new;
          if (cnt_new != '0 && cell_q == lesq_pkg::CELL_EMPTY) begin
            cw_en = 1'b1;
            cw_addr = {st_row_r, st_col_r};
            cw_data = lesq_pkg::CELL_MARKED;
          end
        end
        default: begin
          sw_en = 1'b0;
        end
      endcase
    end
  end

  assign cr_addr = issue ? {r_r, c_r} : {in_row, in_col};
  // sizing reads the side of the cell below; the bottom row masks the wrap
  assign sr_addr = (state_r == lesq_pkg::ST_SIZE) ? {r_r + IW'(1), c_r} : {r_r, c_r};

  always_ff @(posedge clk) begin
    if (cw_en) begin
      cell_mem[cw_addr] <= cw_data;
    end
    cell_q <= cell_mem[cr_addr];
  end

  always_ff @(posedge clk) begin
    if (sw_en) begin
      size_mem[sw_addr] <= sw_data;
    end
    size_q <= size_mem[sr_addr];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_code_nxt = out_code_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
      out_code_nxt = cell_q;
    end
    if (state_r == lesq_pkg::ST_DONE) begin
      out_valid_nxt = 1'b1;
      out_code_nxt = lesq_pkg::CELL_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lesq_pkg::ST_IDLE;
      grid_side_r <= SW'(lesq_pkg::MAX_SIDE);
      best_side_r <= '0;
      out_valid_r <= 1'b0;
      rd_pend_r <= 1'b0;
      st_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      best_side_r <= best_side_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r <= in_fire && (in_op == lesq_pkg::OP_READ);
      st_v_r <= issue;
      if (cfg_wr && cfg_paddr == lesq_pkg::REG_GRID_SIDE) begin
        grid_side_r <= cfg_pwdata[SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;
    c_r <= c_nxt;
    out_code_r <= out_code_nxt;
    st_ph_r <= state_r;
    st_row_r <= r_r;
    st_col_r <= c_r;
    st_first_r <= issue_first;
    st_edge_r <= issue_edge;
    b_r <= b_nxt;
    d_r <= d_nxt;
    cnt_r <= cnt_nxt;
  end
endmodule
`default_nettype wire

// File: sim/largest_empty_square_search_test.sv
`default_nettype none
module largest_empty_square_search_test;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 20;
  localparam int LOAD_SIDE = 16;
  localparam int MAX_SIDE = lesq_pkg::MAX_SIDE;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [1:0] cell_code;
    logic [6:0] best_side;
  } grid_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  largest_empty_square_search dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block state
  logic [1:0]  cell_mirror [MAX_SIDE*MAX_SIDE];
  int          corner_side [MAX_SIDE*MAX_SIDE];
  int          cover_acc [MAX_SIDE+1][MAX_SIDE+1];
  int          side_cfg = 64;
  int          best_seen = 0;

  logic [15:0]  word_q [$];
  grid_result_t result_q [$];
  int  fail_count = 0;
  int  cycle_count = 0;
  bit  word_busy = 0;
  bit  word_took = 0;
  bit  idle_on = 1;
  int  send_gap = 0;
  int  recv_stall = 0;

  function automatic logic [15:0] make_word(logic [1:0] op, int row, int col, bit blk);
    return {1'b0, blk, col[5:0], row[5:0], op};
  endfunction

  function automatic int corner_at(int r, int c, int n);
    if (r >= n || c >= n) return 0;
    return corner_side[r*MAX_SIDE + c];
  endfunction

  function automatic void search_grid();
    int n, best, s, m, v;
    n = (side_cfg > MAX_SIDE) ? MAX_SIDE : side_cfg;
    best = 0;
    for (int r = n - 1; r >= 0; r--) begin
      for (int c = n - 1; c >= 0; c--) begin
        s = 0;
        if (cell_mirror[r*MAX_SIDE + c] != lesq_pkg::CELL_BLOCKED) begin
          m = corner_at(r + 1, c, n);
          if (corner_at(r, c + 1, n) < m) m = corner_at(r, c + 1, n);
          if (corner_at(r + 1, c + 1, n) < m) m = corner_at(r + 1, c + 1, n);
          s = m + 1;
        end
        corner_side[r*MAX_SIDE + c] = s;
        if (s > best) best = s;
      end
    end
    best_seen = best;
    if (best == 0) return;
    for (int r = 0; r <= MAX_SIDE; r++)
      for (int c = 0; c <= MAX_SIDE; c++) cover_acc[r][c] = 0;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (corner_side[r*MAX_SIDE + c] >= best) begin
          cover_acc[r][c] += 1;
          cover_acc[r + best][c] -= 1;
          cover_acc[r][c + best] -= 1;
          cover_acc[r + best][c + best] += 1;
        end
    // prefix sums give coverage count per cell
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        v = cover_acc[r][c];
        if (r > 0) v += cover_acc[r-1][c];
        if (c > 0) v += cover_acc[r][c-1];
        if (r > 0 && c > 0) v -= cover_acc[r-1][c-1];
        cover_acc[r][c] = v;
        if (v > 0 && cell_mirror[r*MAX_SIDE + c] == lesq_pkg::CELL_EMPTY)
          cell_mirror[r*MAX_SIDE + c] = lesq_pkg::CELL_MARKED;
      end
  endfunction

  function automatic void predict_word(logic [15:0] w);
    logic [1:0] op;
    int addr;
    grid_result_t res;
    op = w[1:0];
    addr = w[7:2] * MAX_SIDE + w[13:8];
    case (op)
      lesq_pkg::OP_WRITE: begin
        cell_mirror[addr] = w[14] ? lesq_pkg::CELL_BLOCKED : lesq_pkg::CELL_EMPTY;
      end
      lesq_pkg::OP_SEARCH: begin
        search_grid();
        res.cell_code = lesq_pkg::CELL_EMPTY;
        res.best_side = best_seen[6:0];
        result_q.push_back(res);
      end
      lesq_pkg::OP_READ: begin
        res.cell_code = cell_mirror[addr];
        res.best_side = best_seen[6:0];
        result_q.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // sample side
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) begin
      predict_word(in_tdata);
      word_took = 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        $error("unexpected word: cell_code %0d best_side %0d",
               out_tdata[1:0], out_tdata[8:2]);
        fail_count++;
      end else begin
        grid_result_t e;
        e = result_q.pop_front();
        if (out_tdata[1:0] !== e.cell_code) begin
          $error("cell_code expected %0d actual %0d", e.cell_code, out_tdata[1:0]);
          fail_count++;
        end
        if (out_tdata[8:2] !== e.best_side) begin
          $error("best_side expected %0d actual %0d", e.best_side, out_tdata[8:2]);
          fail_count++;
        end
      end
      recv_stall = idle_on ? $urandom_range(0, 3) : 0;
    end
  end

  // word driver
  always @(negedge clk) begin
    if (word_took) begin
      word_took = 0;
      word_busy = 0;
    end
    if (!word_busy) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (rst_n && word_q.size() > 0) begin
        in_tdata <= word_q.pop_front();
        in_tvalid <= 1'b1;
        word_busy = 1;
        send_gap = idle_on ? $urandom_range(0, 3) : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result stall
  always @(negedge clk) begin
    if (recv_stall > 0) begin
      recv_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n;
    end
  end

  task automatic drain();
    wait (word_q.size() == 0 && !word_busy && result_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_grid_side(int value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {lesq_pkg::REG_GRID_SIDE[0], 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    side_cfg = value;
  endtask

  // every cell touched here lies inside the loaded corner of the store
  task automatic random_phase(int side, int count);
    int r, c, pick;
    for (int k = 0; k < count; k++) begin
      r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, LOAD_SIDE - 1)
                                      : $urandom_range(0, side - 1);
      c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, LOAD_SIDE - 1)
                                      : $urandom_range(0, side - 1);
      pick = $urandom_range(0, 99);
      if (pick < 55)
        word_q.push_back(make_word(lesq_pkg::OP_WRITE, r, c, $urandom_range(0, 3) == 0));
      else if (pick < 90)
        word_q.push_back(make_word(lesq_pkg::OP_READ, r, c, 1'($urandom_range(0, 1))));
      else if (pick < 97)
        word_q.push_back(make_word(lesq_pkg::OP_SEARCH, r, c, 1'($urandom_range(0, 1))));
      else
        word_q.push_back(make_word(OP_NONE, r, c, 1'($urandom_range(0, 1))));
    end
    word_q.push_back(make_word(lesq_pkg::OP_SEARCH, 0, 0, 0));
    for (int k = 0; k < 6; k++)
      word_q.push_back(make_word(lesq_pkg::OP_READ, $urandom_range(0, side - 1),
                                 $urandom_range(0, side - 1), 0));
  endtask

  initial begin
    int sides [7] = '{1, 2, 3, 7, 12, 16, 5};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // load the corner in use so no read touches an unwritten cell
    idle_on = 0;
    for (int a = 0; a < LOAD_SIDE*LOAD_SIDE; a++)
      word_q.push_back(make_word(lesq_pkg::OP_WRITE, a / LOAD_SIDE, a % LOAD_SIDE, 0));
    drain();
    idle_on = 1;
    set_grid_side(LOAD_SIDE);

    // read before any search, then an all-empty grid
    word_q.push_back(make_word(lesq_pkg::OP_READ, 15, 15, 1));
    word_q.push_back(make_word(lesq_pkg::OP_SEARCH, 15, 15, 1));
    word_q.push_back(make_word(lesq_pkg::OP_READ, 0, 0, 0));
    word_q.push_back(make_word(lesq_pkg::OP_READ, 15, 0, 0));
    word_q.push_back(make_word(OP_NONE, 15, 15, 1));
    word_q.push_back(make_word(lesq_pkg::OP_WRITE, 15, 15, 1));
    word_q.push_back(make_word(lesq_pkg::OP_WRITE, 0, 0, 1));
    word_q.push_back(make_word(lesq_pkg::OP_WRITE, 63, 63, 1));
    word_q.push_back(make_word(lesq_pkg::OP_READ, 15, 15, 0));
    word_q.push_back(make_word(lesq_pkg::OP_READ, 0, 0, 0));
    word_q.push_back(make_word(lesq_pkg::OP_SEARCH, 0, 0, 0));
    word_q.push_back(make_word(lesq_pkg::OP_READ, 0, 15, 0));
    word_q.push_back(make_word(lesq_pkg::OP_READ, 15, 15, 0));
    word_q.push_back(make_word(lesq_pkg::OP_READ, 8, 8, 0));
    word_q.push_back(make_word(lesq_pkg::OP_READ, 63, 63, 0));
    drain();

    // empty grid in use
    set_grid_side(0);
    word_q.push_back(make_word(lesq_pkg::OP_SEARCH, 0, 0, 0));
    word_q.push_back(make_word(lesq_pkg::OP_READ, 1, 1, 0));
    drain();

    // one-cell grid, blocked then empty
    set_grid_side(1);
    word_q.push_back(make_word(lesq_pkg::OP_SEARCH, 0, 0, 0));
    word_q.push_back(make_word(lesq_pkg::OP_WRITE, 0, 0, 0));
    word_q.push_back(make_word(lesq_pkg::OP_SEARCH, 0, 0, 0));
    word_q.push_back(make_word(lesq_pkg::OP_READ, 0, 0, 0));
    word_q.push_back(make_word(lesq_pkg::OP_READ, 1, 1, 0));
    drain();

    for (int p = 0; p < 7; p++) begin
      set_grid_side(sides[p]);
      idle_on = (p != 3);
      random_phase(sides[p], 32);
      drain();
    end

    // back to the whole loaded corner with random content
    idle_on = 1;
    set_grid_side(LOAD_SIDE);
    random_phase(LOAD_SIDE, 16);
    drain();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
